// ===== src/cfp_pkg.sv =====
// shared constants for the checksummed frame parser
package cfp_pkg;

	// frame header bytes
	localparam logic [7:0] HDR_FIRST  = 8'h3A;
	localparam logic [7:0] HDR_SECOND = 8'h3B;

	// default payload store depth
	localparam int MAX_PAYLOAD_DEF = 64;

	// configuration register indexes
	localparam int          CFG_IDX_W          = 1;
	localparam logic [0:0]  CFG_FUNC_CODE      = 1'b0;
	localparam logic [0:0]  CFG_MAX_LEN        = 1'b1;

	// configuration reset values
	localparam logic [7:0]  FUNC_CODE_RST      = 8'h01;
	localparam logic [6:0]  MAX_LEN_RST        = 7'd64;

	// result kinds
	localparam logic [1:0]  KIND_PAYLOAD       = 2'd0;
	localparam logic [1:0]  KIND_CSUM_ERR      = 2'd1;
	localparam logic [1:0]  KIND_EMPTY         = 2'd2;

endpackage

// ===== src/checksummed_frame_parser_core.sv =====
// checksummed frame parser: header hunt, payload store, checksum check, read-out
// a checksum item loads an error or empty result into the output register on
// acceptance; payload results go through the store's registered read port first.
// throughput: one received item per cycle, but a checksum item waits while a result
// is held, and input is held during read-out, which has one store read in flight.
// reset: hunt restarts, counters clear, registers go to code 1 and limit 64; store kept
module checksummed_frame_parser_core #(
	parameter int MAX_PAYLOAD = cfp_pkg::MAX_PAYLOAD_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [7:0]                   rx_byte,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [1:0]                   kind,
	output logic [7:0]                   payload_byte,
	output logic                         last,
	output logic [31:0]                  good_frames,
	output logic [31:0]                  error_frames,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [cfp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]                   cfg_data
);

	localparam int LEN_W  = $clog2(MAX_PAYLOAD + 1);
	localparam int ADDR_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

	typedef enum logic [2:0] {
		ST_HDR1,
		ST_HDR2,
		ST_CODE,
		ST_LEN,
		ST_DATA,
		ST_SUM,
		ST_EMIT
	} state_t;

	state_t             st_q;
	logic [7:0]         func_code_q;
	logic [6:0]         max_len_q;
	logic [7:0]         frame_code_q;
	logic [LEN_W-1:0]   frame_len_q;
	logic [LEN_W-1:0]   taken_q;
	logic [LEN_W-1:0]   rd_idx_q;
	logic               rd_pend_q;
	logic [7:0]         sum_q;
	logic [31:0]        good_cnt_q;
	logic [31:0]        err_cnt_q;
	logic               out_valid_q;
	logic [1:0]         kind_q;
	logic [7:0]         payload_q;
	logic               last_q;

	logic [7:0]         store_mem [MAX_PAYLOAD];
	logic [7:0]         rd_data_q;

	logic               in_acc;
	logic               out_free;
	logic               rd_en;
	logic               wr_en;
	logic [7:0]         limit;
	logic               rd_last;

	assign in_ready  = (st_q != ST_EMIT) && !((st_q == ST_SUM) && out_valid_q);
	assign in_acc    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign rd_en     = (st_q == ST_EMIT) && !rd_pend_q && out_free;
	assign wr_en     = in_acc && (st_q == ST_DATA);
	assign rd_last   = (rd_idx_q + LEN_W'(1)) == frame_len_q;
	assign cfg_ready = 1'b1;

	// effective length limit is the smaller of the register and the store depth
	assign limit = ({1'b0, max_len_q} > 8'(MAX_PAYLOAD)) ? 8'(MAX_PAYLOAD) : {1'b0, max_len_q};

	assign out_valid    = out_valid_q;
	assign kind         = kind_q;
	assign payload_byte = payload_q;
	assign last         = last_q;
	// counters only move on a checksum item, which waits for the output to drain
	assign good_frames  = good_cnt_q;
	assign error_frames = err_cnt_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			store_mem[taken_q[ADDR_W-1:0]] <= rx_byte;
		end
		if (rd_en) begin
			rd_data_q <= store_mem[rd_idx_q[ADDR_W-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q         <= ST_HDR1;
			func_code_q  <= cfp_pkg::FUNC_CODE_RST;
			max_len_q    <= cfp_pkg::MAX_LEN_RST;
			frame_code_q <= '0;
			frame_len_q  <= '0;
			taken_q      <= '0;
			rd_idx_q     <= '0;
			rd_pend_q    <= 1'b0;
			sum_q        <= '0;
			good_cnt_q   <= '0;
			err_cnt_q    <= '0;
			out_valid_q  <= 1'b0;
			kind_q       <= cfp_pkg::KIND_PAYLOAD;
			payload_q    <= '0;
			last_q       <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					cfp_pkg::CFG_FUNC_CODE: func_code_q <= cfg_data;
					cfp_pkg::CFG_MAX_LEN:   max_len_q   <= cfg_data[6:0];
					default: ;
				endcase
			end

			// a pending read-out item refills the output register in the same cycle
			if (out_valid_q && out_ready && !((st_q == ST_EMIT) && rd_pend_q)) begin
				out_valid_q <= 1'b0;
			end

			case (st_q)
				ST_HDR1: begin
					if (in_acc && rx_byte == cfp_pkg::HDR_FIRST) begin
						st_q <= ST_HDR2;
					end
				end
				ST_HDR2: begin
					if (in_acc) begin
						if (rx_byte == cfp_pkg::HDR_SECOND) begin
							st_q <= ST_CODE;
						end else if (rx_byte != cfp_pkg::HDR_FIRST) begin
							st_q <= ST_HDR1;
						end
					end
				end
				ST_CODE: begin
					if (in_acc) begin
						if (rx_byte == func_code_q) begin
							frame_code_q <= rx_byte;
							st_q         <= ST_LEN;
						end else begin
							frame_code_q <= '0;
							st_q         <= ST_HDR1;
						end
					end
				end
				ST_LEN: begin
					if (in_acc) begin
						if (rx_byte <= limit) begin
							frame_len_q <= LEN_W'(rx_byte);
							taken_q     <= '0;
							sum_q       <= 8'(cfp_pkg::HDR_FIRST + cfp_pkg::HDR_SECOND
								+ frame_code_q + rx_byte);
							st_q        <= (rx_byte == 8'd0) ? ST_SUM : ST_DATA;
						end else begin
							frame_len_q <= '0;
							st_q        <= ST_HDR1;
						end
					end
				end
				ST_DATA: begin
					if (in_acc) begin
						taken_q <= taken_q + LEN_W'(1);
						sum_q   <= sum_q + rx_byte;
						if ((taken_q + LEN_W'(1)) == frame_len_q) begin
							st_q <= ST_SUM;
						end
					end
				end
				ST_SUM: begin
					if (in_acc) begin
						sum_q   <= '0;
						taken_q <= '0;
						if (sum_q == rx_byte) begin
							good_cnt_q <= good_cnt_q + 32'd1;
							if (frame_len_q == '0) begin
								out_valid_q <= 1'b1;
								kind_q      <= cfp_pkg::KIND_EMPTY;
								payload_q   <= '0;
								last_q      <= 1'b1;
								st_q        <= ST_HDR1;
							end else begin
								rd_idx_q  <= '0;
								rd_pend_q <= 1'b0;
								st_q      <= ST_EMIT;
							end
						end else begin
							err_cnt_q   <= err_cnt_q + 32'd1;
							out_valid_q <= 1'b1;
							kind_q      <= cfp_pkg::KIND_CSUM_ERR;
							payload_q   <= '0;
							last_q      <= 1'b1;
							frame_len_q <= '0;
							st_q        <= ST_HDR1;
						end
						frame_code_q <= '0;
					end
				end
				ST_EMIT: begin
					// one read in flight, then the byte moves to the output register
					if (rd_en) begin
						rd_pend_q <= 1'b1;
					end
					if (rd_pend_q && out_free) begin
						out_valid_q <= 1'b1;
						kind_q      <= cfp_pkg::KIND_PAYLOAD;
						payload_q   <= rd_data_q;
						last_q      <= rd_last;
						rd_pend_q   <= 1'b0;
						rd_idx_q    <= rd_idx_q + LEN_W'(1);
						if (rd_last) begin
							frame_len_q <= '0;
							st_q        <= ST_HDR1;
						end
					end
				end
				default: begin
					st_q <= ST_HDR1;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_last_leaves_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && last_q) |-> (st_q != ST_EMIT))
		else $error("read-out still running after last item");

	a_rd_idx_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_EMIT) |-> (rd_idx_q < frame_len_q))
		else $error("read-out index past frame length");

	a_count_on_sum: assert property (@(posedge clk) disable iff (!arst_n)
		((in_acc && st_q != ST_SUM) || st_q == ST_EMIT) |=>
		($stable(good_cnt_q) && $stable(err_cnt_q)))
		else $error("frame counter moved outside checksum item");
`endif

endmodule

// ===== verif/tb.sv =====
// testbench for the checksummed frame parser: byte stream stimulus, frame predictor, result checks
`timescale 1ns / 100ps

module tb;

	localparam int CYCLE_LIMIT = 200000;
	localparam int STORE_DEPTH = cfp_pkg::MAX_PAYLOAD_DEF;
	localparam int STORE_AW    = $clog2(STORE_DEPTH);

	typedef logic [7:0] byte_q_t[$];

	typedef enum logic [2:0] {
		HUNT_FIRST,
		HUNT_SECOND,
		TAKE_CODE,
		TAKE_LEN,
		TAKE_PAYLOAD,
		TAKE_SUM
	} hunt_phase_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  data;
		logic        last;
		logic [31:0] good;
		logic [31:0] bad;
	} frame_result_t;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          in_valid = 1'b0;
	logic                          in_ready;
	logic [7:0]                    rx_byte = 8'h00;
	logic                          out_valid;
	logic                          out_ready = 1'b0;
	logic [1:0]                    kind;
	logic [7:0]                    payload_byte;
	logic                          last;
	logic [31:0]                   good_frames;
	logic [31:0]                   error_frames;
	logic                          cfg_valid = 1'b0;
	logic                          cfg_ready;
	logic [cfp_pkg::CFG_IDX_W-1:0] cfg_index = cfp_pkg::CFG_FUNC_CODE;
	logic [7:0]                    cfg_data = 8'h00;

	bit gaps_on = 1'b1;
	int mismatches = 0;
	int cycle_count = 0;
	int bytes_sent = 0;

	// frame predictor state
	logic [7:0]    accepted_code = cfp_pkg::FUNC_CODE_RST;
	logic [6:0]    len_limit = cfp_pkg::MAX_LEN_RST;
	hunt_phase_t   hunt_phase = HUNT_FIRST;
	logic [7:0]    frame_code = 8'h00;
	logic [6:0]    frame_len = 7'd0;
	logic [6:0]    bytes_taken = 7'd0;
	logic [7:0]    running_sum = 8'h00;
	logic [7:0]    payload_store [STORE_DEPTH];
	logic [31:0]   good_total = 32'd0;
	logic [31:0]   bad_total = 32'd0;
	frame_result_t expected_results[$];

	checksummed_frame_parser_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.rx_byte      (rx_byte),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.kind         (kind),
		.payload_byte (payload_byte),
		.last         (last),
		.good_frames  (good_frames),
		.error_frames (error_frames),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	always @(posedge clk) begin
		out_ready <= !gaps_on || ($urandom_range(0, 99) >= 9);
	end

	function automatic int effective_limit();
		return (int'(len_limit) > STORE_DEPTH) ? STORE_DEPTH : int'(len_limit);
	endfunction

	function automatic void queue_result(logic [1:0] k, logic [7:0] data, logic is_last);
		frame_result_t r;
		r.kind = k;
		r.data = data;
		r.last = is_last;
		r.good = good_total;
		r.bad  = bad_total;
		expected_results.push_back(r);
	endfunction

	// advances the frame predictor by one accepted item
	function automatic void predict_byte(logic [7:0] b);
		case (hunt_phase)
			HUNT_FIRST: begin
				if (b == cfp_pkg::HDR_FIRST)
					hunt_phase = HUNT_SECOND;
			end
			HUNT_SECOND: begin
				if (b == cfp_pkg::HDR_SECOND)
					hunt_phase = TAKE_CODE;
				else if (b != cfp_pkg::HDR_FIRST)
					hunt_phase = HUNT_FIRST;
			end
			TAKE_CODE: begin
				if (b == accepted_code) begin
					frame_code = b;
					hunt_phase = TAKE_LEN;
				end else begin
					frame_code = 8'h00;
					hunt_phase = HUNT_FIRST;
				end
			end
			TAKE_LEN: begin
				if (int'(b) <= effective_limit()) begin
					frame_len = b[6:0];
					bytes_taken = 7'd0;
					running_sum = 8'(cfp_pkg::HDR_FIRST + cfp_pkg::HDR_SECOND
						+ frame_code + b);
					hunt_phase = (b == 8'h00) ? TAKE_SUM : TAKE_PAYLOAD;
				end else begin
					frame_len = 7'd0;
					hunt_phase = HUNT_FIRST;
				end
			end
			TAKE_PAYLOAD: begin
				if (bytes_taken < frame_len) begin
					payload_store[bytes_taken[STORE_AW-1:0]] = b;
					bytes_taken = bytes_taken + 7'd1;
					running_sum = running_sum + b;
				end
				if (bytes_taken >= frame_len)
					hunt_phase = TAKE_SUM;
			end
			TAKE_SUM: begin
				if (running_sum == b) begin
					good_total = good_total + 32'd1;
					if (frame_len == 7'd0)
						queue_result(cfp_pkg::KIND_EMPTY, 8'h00, 1'b1);
					else
						for (int i = 0; i < int'(frame_len); i++)
							queue_result(cfp_pkg::KIND_PAYLOAD,
								payload_store[STORE_AW'(i)],
								i + 1 == int'(frame_len));
				end else begin
					bad_total = bad_total + 32'd1;
					queue_result(cfp_pkg::KIND_CSUM_ERR, 8'h00, 1'b1);
				end
				frame_code = 8'h00;
				frame_len = 7'd0;
				bytes_taken = 7'd0;
				running_sum = 8'h00;
				hunt_phase = HUNT_FIRST;
			end
			default: hunt_phase = HUNT_FIRST;
		endcase
	endfunction

	always @(posedge clk) begin : check_results
		frame_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				$error("unexpected result: kind %0d, payload_byte %0h", kind, payload_byte);
				mismatches++;
			end else begin
				want = expected_results.pop_front();
				if (kind !== want.kind) begin
					$error("kind: expected %0d, actual %0d", want.kind, kind);
					mismatches++;
				end
				if (payload_byte !== want.data) begin
					$error("payload_byte: expected %0h, actual %0h", want.data, payload_byte);
					mismatches++;
				end
				if (last !== want.last) begin
					$error("last: expected %0b, actual %0b", want.last, last);
					mismatches++;
				end
				if (good_frames !== want.good) begin
					$error("good_frames: expected %0d, actual %0d", want.good, good_frames);
					mismatches++;
				end
				if (error_frames !== want.bad) begin
					$error("error_frames: expected %0d, actual %0d", want.bad, error_frames);
					mismatches++;
				end
			end
		end
	end

	// valid stays high from one item to the next unless a gap is drawn
	task automatic send_byte(input logic [7:0] b);
		if (gaps_on && $urandom_range(0, 99) < 9) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		do @(posedge clk); while (!in_ready);
		predict_byte(b);
		bytes_sent++;
	endtask

	task automatic send_seq(input byte_q_t seq);
		foreach (seq[i])
			send_byte(seq[i]);
	endtask

	task automatic send_frame(input logic [7:0] code, input byte_q_t payload, input bit bad_sum);
		byte_q_t seq;
		logic [7:0] csum;
		seq = {cfp_pkg::HDR_FIRST, cfp_pkg::HDR_SECOND, code, 8'(payload.size())};
		foreach (payload[i])
			seq.push_back(payload[i]);
		csum = 8'h00;
		foreach (seq[i])
			csum = csum + seq[i];
		if (bad_sum)
			csum = csum + 8'($urandom_range(1, 255));
		seq.push_back(csum);
		send_seq(seq);
	endtask

	task automatic send_random_frame(input logic [7:0] code, input int len, input bit bad_sum);
		byte_q_t payload;
		repeat (len) payload.push_back(8'($urandom));
		send_frame(code, payload, bad_sum);
	endtask

	task automatic drain_results(input int settle);
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_results.size() != 0) @(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	task automatic write_reg(input logic [cfp_pkg::CFG_IDX_W-1:0] idx, input logic [7:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		if (idx == cfp_pkg::CFG_FUNC_CODE)
			accepted_code = data;
		else if (idx == cfp_pkg::CFG_MAX_LEN)
			len_limit = data[6:0];
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// parser may still be busy after the last result, so let it settle first
	task automatic set_config(input logic [7:0] code, input logic [7:0] limit);
		drain_results(8);
		write_reg(cfp_pkg::CFG_FUNC_CODE, code);
		write_reg(cfp_pkg::CFG_MAX_LEN, limit);
	endtask

	task automatic test_directed_frames();
		byte_q_t none;
		byte_q_t seq;
		// empty good frame with the reset code and limit
		send_frame(cfp_pkg::FUNC_CODE_RST, none, 1'b0);
		// payload extremes
		seq = {8'hFF, 8'h00};
		send_frame(cfp_pkg::FUNC_CODE_RST, seq, 1'b0);
		// repeated first header byte, then a checksum error
		seq = {cfp_pkg::HDR_FIRST, cfp_pkg::HDR_FIRST, cfp_pkg::HDR_SECOND,
			cfp_pkg::FUNC_CODE_RST, 8'h00, 8'h00};
		send_seq(seq);
		// wrong code and an oversize length are dropped
		seq = {cfp_pkg::HDR_FIRST, cfp_pkg::HDR_SECOND, 8'h02};
		send_seq(seq);
		seq = {cfp_pkg::HDR_FIRST, cfp_pkg::HDR_SECOND, cfp_pkg::FUNC_CODE_RST, 8'hFF};
		send_seq(seq);
		send_random_frame(cfp_pkg::FUNC_CODE_RST, 1, 1'b0);
	endtask

	task automatic test_register_extremes();
		byte_q_t none;
		byte_q_t seq;
		set_config(8'h00, 8'h00);
		send_frame(8'h00, none, 1'b0);
		seq = {cfp_pkg::HDR_FIRST, cfp_pkg::HDR_SECOND, 8'h00, 8'h01};
		send_seq(seq);
		seq = {cfp_pkg::HDR_FIRST, cfp_pkg::HDR_SECOND, 8'h01};
		send_seq(seq);
		// limit above the store depth is clamped to the depth
		set_config(8'hFF, 8'hFF);
		send_random_frame(8'hFF, STORE_DEPTH, 1'b0);
		seq = {cfp_pkg::HDR_FIRST, cfp_pkg::HDR_SECOND, 8'hFF, 8'(STORE_DEPTH + 1)};
		send_seq(seq);
		set_config(8'hA5, 8'(STORE_DEPTH));
		send_random_frame(8'hA5, 3, 1'b1);
		send_random_frame(8'hA5, 3, 1'b0);
		set_config(8'h5A, 8'd3);
		send_random_frame(8'h5A, 3, 1'b0);
		seq = {cfp_pkg::HDR_FIRST, cfp_pkg::HDR_SECOND, 8'h5A, 8'd4};
		send_seq(seq);
	endtask

	task automatic test_drain_between_frames();
		set_config(8'h3C, 8'd8);
		repeat (4) begin
			send_random_frame(8'h3C, $urandom_range(0, 8), $urandom_range(0, 3) == 0);
			drain_results(0);
		end
	endtask

	task automatic test_random_traffic();
		int round_start;
		int pick;
		int lim;
		int len;
		byte_q_t seq;
		for (int round = 0; round < 4; round++) begin
			case (round)
				0: set_config(8'($urandom), 8'($urandom_range(1, 64)));
				1: set_config(8'h00, 8'd64);
				2: set_config(8'hFF, 8'($urandom_range(0, 8)));
				default: set_config(8'($urandom), 8'($urandom_range(0, 127)));
			endcase
			// one round runs with no idling on either side
			gaps_on = (round != 1);
			lim = effective_limit();
			round_start = bytes_sent;
			while (bytes_sent - round_start < 20) begin
				pick = $urandom_range(0, 99);
				if (pick < 70) begin
					len = ($urandom_range(0, 11) == 0) ? lim
						: $urandom_range(0, (lim < 6) ? lim : 6);
					if ($urandom_range(0, 5) == 0)
						send_byte(cfp_pkg::HDR_FIRST);
					send_random_frame(accepted_code, len, $urandom_range(0, 4) == 0);
				end else if (pick < 80) begin
					seq = {cfp_pkg::HDR_FIRST, cfp_pkg::HDR_SECOND,
						accepted_code ^ 8'($urandom_range(1, 255))};
					send_seq(seq);
				end else if (pick < 88) begin
					seq = {cfp_pkg::HDR_FIRST, cfp_pkg::HDR_SECOND, accepted_code,
						8'($urandom_range(lim + 1, 255))};
					send_seq(seq);
				end else begin
					// noise, biased towards header bytes
					repeat ($urandom_range(1, 6)) begin
						case ($urandom_range(0, 3))
							0: send_byte(cfp_pkg::HDR_FIRST);
							1: send_byte(cfp_pkg::HDR_SECOND);
							default: send_byte(8'($urandom));
						endcase
					end
				end
			end
		end
		gaps_on = 1'b1;
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_frames();
		test_register_extremes();
		test_drain_between_frames();
		test_random_traffic();
		drain_results(20);
		if (mismatches == 0 && expected_results.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
